// ===== hdl/dtq_pkg.sv =====
// Shared types and codes for the delta-list timer queue.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package dtq_pkg;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  task_id;
      logic [15:0] delay;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        head_valid;
      logic [7:0]  head_id;
      logic [15:0] head_delay;
      logic [4:0]  entry_count;
   } rsp_type;

   // One stored list entry.
   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] delta;
   } entry_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_WALK_RD,
      ENG_WALK_CHK,
      ENG_SHIFT_RD,
      ENG_SHIFT_WR,
      ENG_PLACE,
      ENG_FINISH
   } eng_state_type;

   localparam logic [16:0] DELTA_MAX = 17'h0FFFF;

endpackage

`default_nettype wire

// ===== hdl/dtq_front.sv =====
// Front end of the timer queue: a two-entry request queue ahead of the list engine.
// Depends on dtq_pkg for the request type.
`default_nettype none

module dtq_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   output logic                 full,
   input  wire dtq_pkg::req_type push_data,
   output logic                 cmd_valid,
   output dtq_pkg::req_type     cmd_data,
   input  wire logic            cmd_take
);

   dtq_pkg::req_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_wr, do_rd;

   assign full      = (fill_ff == 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd_data  = slot_ff[rd_ptr_ff];
   assign do_wr     = push && !full;
   assign do_rd     = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_wr;
      rd_ptr_in = rd_ptr_ff ^ do_rd;
      fill_in   = fill_ff;
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/dtq_engine.sv =====
// Back end of the timer queue: list memory, walk/shift sequencer and result register.
// Depends on dtq_pkg for entry, request, result and state types.
`default_nettype none

module dtq_engine #(
   parameter int DEPTH = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            cmd_valid,
   input  wire dtq_pkg::req_type cmd_data,
   output logic                 cmd_take,
   output logic                 res_empty,
   input  wire logic            res_pop,
   output dtq_pkg::rsp_type     res_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   dtq_pkg::entry_type mem [DEPTH];

   dtq_pkg::eng_state_type state_ff, state_in;
   dtq_pkg::op_type     op_ff, op_in;
   dtq_pkg::status_type status_ff, status_in;
   logic [7:0]          id_ff, id_in;
   logic [15:0]         rem_ff, rem_in;
   logic [15:0]         save_ff, save_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [CW-1:0]       k_ff, k_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                res_valid_ff, res_valid_in;
   dtq_pkg::rsp_type    res_ff, res_in;
   logic [7:0]          head_id_ff;
   logic [15:0]         head_delay_ff;
   dtq_pkg::entry_type  rd_data_ff;

   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [AW-1:0]       mem_raddr;
   dtq_pkg::entry_type  mem_wdata;
   logic [16:0]         sum;
   logic [CW-1:0]       count_nx;
   logic [CW+4:0]       count_ext;

   assign cmd_take  = (state_ff == dtq_pkg::ENG_IDLE) && cmd_valid && !res_valid_ff;
   assign res_empty = !res_valid_ff;
   assign res_data  = res_ff;
   assign sum       = {1'b0, rd_data_ff.delta} + {1'b0, save_ff};
   assign count_ext = {5'b0, count_nx};

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      id_in        = id_ff;
      rem_in       = rem_ff;
      save_in      = save_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      count_in     = count_ff;
      res_valid_in = res_valid_ff && !res_pop;
      res_in       = res_ff;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff[AW-1:0];
      mem_raddr    = pos_ff[AW-1:0];
      mem_wdata    = '{id: id_ff, delta: rem_ff};
      count_nx     = count_ff;

      case (state_ff)
         dtq_pkg::ENG_IDLE: begin
            if (cmd_take) begin
               op_in     = cmd_data.op;
               id_in     = cmd_data.task_id;
               rem_in    = cmd_data.delay;
               pos_in    = '0;
               status_in = dtq_pkg::ST_DONE;
               if (cmd_data.op == dtq_pkg::OP_INSERT && count_ff == DEPTH_C) begin
                  status_in = dtq_pkg::ST_FULL;
                  state_in  = dtq_pkg::ENG_FINISH;
               end else begin
                  state_in = dtq_pkg::ENG_WALK_RD;
               end
            end
         end
         dtq_pkg::ENG_WALK_RD: begin
            // Ran off the end: append on insert, report a miss on remove.
            if (pos_ff == count_ff) begin
               if (op_ff == dtq_pkg::OP_INSERT) begin
                  state_in = dtq_pkg::ENG_PLACE;
               end else begin
                  status_in = dtq_pkg::ST_NOT_FOUND;
                  state_in  = dtq_pkg::ENG_FINISH;
               end
            end else begin
               mem_raddr = pos_ff[AW-1:0];
               state_in  = dtq_pkg::ENG_WALK_CHK;
            end
         end
         dtq_pkg::ENG_WALK_CHK: begin
            if (op_ff == dtq_pkg::OP_INSERT) begin
               if (rem_ff > rd_data_ff.delta) begin
                  rem_in   = rem_ff - rd_data_ff.delta;
                  pos_in   = pos_ff + ONE_C;
                  state_in = dtq_pkg::ENG_WALK_RD;
               end else begin
                  k_in     = count_ff;
                  state_in = dtq_pkg::ENG_SHIFT_RD;
               end
            end else begin
               if (rd_data_ff.id == id_ff) begin
                  save_in  = rd_data_ff.delta;
                  k_in     = pos_ff;
                  state_in = dtq_pkg::ENG_SHIFT_RD;
               end else begin
                  pos_in   = pos_ff + ONE_C;
                  state_in = dtq_pkg::ENG_WALK_RD;
               end
            end
         end
         dtq_pkg::ENG_SHIFT_RD: begin
            if (op_ff == dtq_pkg::OP_INSERT) begin
               // Open a gap at pos by moving entries up, tail first.
               if (k_ff == pos_ff) begin
                  state_in = dtq_pkg::ENG_PLACE;
               end else begin
                  mem_raddr = k_ff[AW-1:0] - AW'(1);
                  state_in  = dtq_pkg::ENG_SHIFT_WR;
               end
            end else begin
               // Close the gap at pos by moving entries down.
               if (k_ff + ONE_C >= count_ff) begin
                  state_in = dtq_pkg::ENG_FINISH;
               end else begin
                  mem_raddr = k_ff[AW-1:0] + AW'(1);
                  state_in  = dtq_pkg::ENG_SHIFT_WR;
               end
            end
         end
         dtq_pkg::ENG_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = k_ff[AW-1:0];
            mem_wdata = rd_data_ff;
            if (op_ff == dtq_pkg::OP_INSERT) begin
               if (k_ff - ONE_C == pos_ff) begin
                  mem_wdata.delta = rd_data_ff.delta - rem_ff;
               end
               k_in = k_ff - ONE_C;
            end else begin
               if (k_ff == pos_ff) begin
                  mem_wdata.delta = (sum > dtq_pkg::DELTA_MAX) ? 16'hFFFF : sum[15:0];
               end
               k_in = k_ff + ONE_C;
            end
            state_in = dtq_pkg::ENG_SHIFT_RD;
         end
         dtq_pkg::ENG_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff[AW-1:0];
            mem_wdata = '{id: id_ff, delta: rem_ff};
            state_in  = dtq_pkg::ENG_FINISH;
         end
         dtq_pkg::ENG_FINISH: begin
            if (status_ff == dtq_pkg::ST_DONE) begin
               count_nx = (op_ff == dtq_pkg::OP_INSERT) ? count_ff + ONE_C : count_ff - ONE_C;
            end
            count_in               = count_nx;
            res_in.status          = status_ff;
            res_in.head_valid      = (count_nx != '0);
            res_in.head_id         = (count_nx != '0) ? head_id_ff : 8'd0;
            res_in.head_delay      = (count_nx != '0) ? head_delay_ff : 16'd0;
            res_in.entry_count     = count_ext[4:0];
            res_valid_in           = 1'b1;
            state_in               = dtq_pkg::ENG_IDLE;
         end
         default: begin
            state_in = dtq_pkg::ENG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtq_pkg::ENG_IDLE;
         count_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      status_ff <= status_in;
      id_ff     <= id_in;
      rem_ff    <= rem_in;
      save_ff   <= save_in;
      pos_ff    <= pos_in;
      k_ff      <= k_in;
      res_ff    <= res_in;
   end

   // List storage; head copy follows every write to the first entry.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (mem_we && mem_waddr == '0) begin
         head_id_ff    <= mem_wdata.id;
         head_delay_ff <= mem_wdata.delta;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/delta_timer_queue.sv =====
// Top level of the delta-list timer queue: request queue feeding the list engine.
// Depends on dtq_pkg, dtq_front and dtq_engine.
//
// Usage:
//  - Requests enter through req_push/req_full with req_data (op, task_id, delay).
//    A request is taken on a clock edge with req_push high and req_full low.
//  - Every request yields exactly one result on rsp_data (status, head of list,
//    entry count). It is shown while rsp_empty is low and leaves on an edge with
//    rsp_pop high.
//  - A two-entry request queue decouples the producer from the engine, so new
//    requests are taken while the engine works or while a result waits.
//  - Operation: the engine walks the list one entry at a time (registered memory
//    read, then compare), then moves the entries behind the insert or remove
//    point one at a time (read, write). A refused insert skips the walk and the
//    moves; the next request starts once the result is popped.
//  - The engine starts a request only once the result slot is free, so a stalled
//    consumer backs up into the request queue and then raises req_full.
//  - Reset empties the list and both queues; the list memory needs no clearing
//    pass since only entries below the entry count are ever read.
`default_nettype none

module delta_timer_queue #(
   parameter int DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire dtq_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output dtq_pkg::rsp_type      rsp_data
);

   logic             cmd_valid;
   logic             cmd_take;
   dtq_pkg::req_type cmd_data;

   // Hold incoming requests until the engine is free.
   dtq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .push_data (req_data),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take)
   );

   // Walk, shift and report; the result register sits inside the engine.
   dtq_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_take  (cmd_take),
      .res_empty (rsp_empty),
      .res_pop   (rsp_pop),
      .res_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for delta_timer_queue: directed table, then random insert/remove traffic.
// Depends on dtq_pkg and the delta_timer_queue RTL; a local list model predicts every result.
`timescale 1ns / 100ps

module tb_top;

   localparam int DEPTH      = 16;
   localparam int RAND_ITEMS = 1825;
   // Comfortable margin over the worst engine pass, waited after the last result.
   localparam int SETTLE     = 4 * DEPTH + 20;

   // One row of the directed plan. Where 'typed' is set, 'result' is the value to expect;
   // otherwise the list model supplies it.
   typedef struct packed {
      dtq_pkg::req_type req;
      bit               typed;
      dtq_pkg::rsp_type result;
   } plan_row_type;

   localparam int PLAN_ROWS = 25;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   dtq_pkg::req_type req_data = '0;
   logic             rsp_empty;
   logic             rsp_pop  = 1'b0;
   dtq_pkg::rsp_type rsp_data;

   // Local copy of the sleeping-task list, in list order.
   logic [7:0]  sleep_ids    [DEPTH];
   logic [15:0] sleep_deltas [DEPTH];
   int          sleep_count = 0;

   dtq_pkg::rsp_type queued_outcomes [$];
   int      error_count = 0;
   bit      push_live   = 1'b0;
   bit      quiet_spell = 1'b0;
   int      pop_hold    = 0;

   plan_row_type directed_plan [0:PLAN_ROWS-1] = '{
      // remove on an empty list: no match, empty head
      '{dtq_pkg::req_type'{dtq_pkg::OP_REMOVE, 8'h00, 16'h0000}, 1'b1,
        dtq_pkg::rsp_type'{dtq_pkg::ST_NOT_FOUND, 1'b0, 8'h00, 16'h0000, 5'd0}},
      // largest id and delay into an empty list
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'hFF, 16'hFFFF}, 1'b1,
        dtq_pkg::rsp_type'{dtq_pkg::ST_DONE, 1'b1, 8'hFF, 16'hFFFF, 5'd1}},
      // zero delay goes in front
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'h00, 16'h0000}, 1'b1,
        dtq_pkg::rsp_type'{dtq_pkg::ST_DONE, 1'b1, 8'h00, 16'h0000, 5'd2}},
      // equal remainder of zero: new entry before the zero-delta head
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'h05, 16'h0000}, 1'b1,
        dtq_pkg::rsp_type'{dtq_pkg::ST_DONE, 1'b1, 8'h05, 16'h0000, 5'd3}},
      // duplicate id with equal delay, then remove the first copy
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'h07, 16'h0064}, 1'b0, '0},
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'h07, 16'h0064}, 1'b0, '0},
      '{dtq_pkg::req_type'{dtq_pkg::OP_REMOVE, 8'h07, 16'hFFFF}, 1'b0, '0},
      // remove the tail entry
      '{dtq_pkg::req_type'{dtq_pkg::OP_REMOVE, 8'hFF, 16'h0000}, 1'b0, '0},
      // no match on a non-empty list
      '{dtq_pkg::req_type'{dtq_pkg::OP_REMOVE, 8'h33, 16'h5A5A}, 1'b0, '0},
      // fill the list up to DEPTH entries
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'h80, 16'h8000}, 1'b0, '0},
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'h40, 16'h0001}, 1'b0, '0},
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'h20, 16'h4000}, 1'b0, '0},
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'h10, 16'h7FFF}, 1'b0, '0},
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'h08, 16'h0064}, 1'b0, '0},
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'h04, 16'h0100}, 1'b0, '0},
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'h02, 16'h00C8}, 1'b0, '0},
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'h01, 16'h1234}, 1'b0, '0},
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'hFE, 16'h0000}, 1'b0, '0},
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'hC3, 16'hFFFE}, 1'b0, '0},
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'h3C, 16'h2000}, 1'b0, '0},
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'hA5, 16'h0064}, 1'b0, '0},
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'h5A, 16'h0032}, 1'b0, '0},
      // insert into a full list is refused
      '{dtq_pkg::req_type'{dtq_pkg::OP_INSERT, 8'hAA, 16'h5555}, 1'b0, '0},
      // remove the entry behind the head, then the next one, folding deltas forward
      '{dtq_pkg::req_type'{dtq_pkg::OP_REMOVE, 8'h05, 16'h0000}, 1'b0, '0},
      '{dtq_pkg::req_type'{dtq_pkg::OP_REMOVE, 8'h00, 16'h0000}, 1'b0, '0}
   };

   delta_timer_queue #(
      .DEPTH(DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Apply one request to the local list and return the result it should produce.
   function automatic dtq_pkg::rsp_type apply_timer_op(input dtq_pkg::req_type r);
      dtq_pkg::rsp_type res;
      int               pos;
      int               k;
      logic [15:0]      remain;
      logic [16:0]      merged;
      res = '0;
      pos = 0;
      if (r.op == dtq_pkg::OP_INSERT) begin
         if (sleep_count >= DEPTH) begin
            res.status = dtq_pkg::ST_FULL;
         end else begin
            // walk past every entry whose delta is smaller than what is left
            remain = r.delay;
            while (pos < sleep_count && remain > sleep_deltas[pos]) begin
               remain = remain - sleep_deltas[pos];
               pos++;
            end
            if (pos < sleep_count)
               sleep_deltas[pos] = sleep_deltas[pos] - remain;
            for (k = sleep_count; k > pos; k--) begin
               sleep_ids[k]    = sleep_ids[k-1];
               sleep_deltas[k] = sleep_deltas[k-1];
            end
            sleep_ids[pos]    = r.task_id;
            sleep_deltas[pos] = remain;
            sleep_count++;
            res.status = dtq_pkg::ST_DONE;
         end
      end else begin
         while (pos < sleep_count && sleep_ids[pos] != r.task_id)
            pos++;
         if (pos >= sleep_count) begin
            res.status = dtq_pkg::ST_NOT_FOUND;
         end else begin
            // hand the removed delta on to the follower, clamped to 16 bits
            if (pos + 1 < sleep_count) begin
               merged = {1'b0, sleep_deltas[pos+1]} + {1'b0, sleep_deltas[pos]};
               sleep_deltas[pos+1] = (merged > dtq_pkg::DELTA_MAX) ? 16'hFFFF : merged[15:0];
            end
            for (k = pos; k + 1 < sleep_count; k++) begin
               sleep_ids[k]    = sleep_ids[k+1];
               sleep_deltas[k] = sleep_deltas[k+1];
            end
            sleep_count--;
            res.status = dtq_pkg::ST_DONE;
         end
      end
      if (sleep_count > 0) begin
         res.head_valid = 1'b1;
         res.head_id    = sleep_ids[0];
         res.head_delay = sleep_deltas[0];
      end
      res.entry_count = sleep_count[4:0];
      return res;
   endfunction

   // Mostly short idle spells, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 15) == 0)
         return int'($urandom_range(20, 60));
      return int'($urandom_range(1, 3));
   endfunction

   // Build a random request. Bias towards inserts or removes by phase so the list
   // swings between empty and full; aim removes mostly at held ids and some inserts
   // at an existing absolute delay to hit the equal-delta case.
   function automatic dtq_pkg::req_type make_random_request(input int phase);
      dtq_pkg::req_type r;
      int      insert_pct;
      int      pick;
      int      k;
      int      abs_delay;
      insert_pct = (phase == 1) ? 80 : (phase == 2) ? 20 : 55;
      r.delay    = 16'($urandom);
      if ($urandom_range(0, 99) < insert_pct) begin
         r.op      = dtq_pkg::OP_INSERT;
         r.task_id = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                     : $urandom_range(0, 15));
         case ($urandom_range(0, 5))
            0: r.delay = 16'($urandom_range(0, 15));
            1: r.delay = 16'($urandom_range(0, 1023));
            2: r.delay = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
            3: begin
               if (sleep_count > 0) begin
                  pick      = int'($urandom_range(0, sleep_count - 1));
                  abs_delay = 0;
                  for (k = 0; k <= pick; k++)
                     abs_delay += sleep_deltas[k];
                  r.delay = abs_delay[15:0];
               end
            end
            default: ;
         endcase
      end else begin
         r.op = dtq_pkg::OP_REMOVE;
         if (sleep_count > 0 && $urandom_range(0, 4) != 0)
            r.task_id = sleep_ids[$urandom_range(0, sleep_count - 1)];
         else
            r.task_id = 8'($urandom_range(0, 255));
      end
      return r;
   endfunction

   // Offer one request, wait for it to be taken, then record what it should return.
   task automatic send_request(input dtq_pkg::req_type r, input bit use_typed,
                               input dtq_pkg::rsp_type typed_res);
      int               gap;
      dtq_pkg::rsp_type predicted;
      gap = (!quiet_spell && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         if (push_live)
            req_push <= 1'b0;
         push_live = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push  <= 1'b1;
      req_data  <= r;
      push_live = 1'b1;
      do @(posedge clock); while (req_full);
      predicted = apply_timer_op(r);
      queued_outcomes.push_back(use_typed ? typed_res : predicted);
   endtask

   // Stop offering requests until every outstanding result has come back.
   task automatic hold_until_drained();
      if (push_live)
         req_push <= 1'b0;
      push_live = 1'b0;
      do @(posedge clock); while (queued_outcomes.size() != 0);
   endtask

   task automatic check_result(input dtq_pkg::rsp_type got);
      dtq_pkg::rsp_type want;
      if (queued_outcomes.size() == 0) begin
         $display("%0t: unexpected result %h with nothing outstanding", $time, got);
         error_count++;
      end else begin
         want = queued_outcomes.pop_front();
         if (got.status != want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            error_count++;
         end
         if (got.head_valid != want.head_valid) begin
            $display("%0t: head_valid expected %0d got %0d", $time, want.head_valid,
                     got.head_valid);
            error_count++;
         end
         if (got.head_id != want.head_id) begin
            $display("%0t: head_id expected %h got %h", $time, want.head_id, got.head_id);
            error_count++;
         end
         if (got.head_delay != want.head_delay) begin
            $display("%0t: head_delay expected %h got %h", $time, want.head_delay,
                     got.head_delay);
            error_count++;
         end
         if (got.entry_count != want.entry_count) begin
            $display("%0t: entry_count expected %0d got %0d", $time, want.entry_count,
                     got.entry_count);
            error_count++;
         end
      end
   endtask

   // Result side: check whatever leaves on this edge, then decide whether to pop next cycle.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty)
            check_result(rsp_data);
         if (pop_hold > 0) begin
            rsp_pop <= 1'b0;
            pop_hold--;
         end else begin
            rsp_pop <= 1'b1;
            if (!quiet_spell && $urandom_range(0, 3) == 0)
               pop_hold = pick_gap();
         end
      end
   end

   // Stimulus: reset, directed table, random traffic, then drain and report.
   initial begin
      int phase;
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      for (n = 0; n < PLAN_ROWS; n++)
         send_request(directed_plan[n].req, directed_plan[n].typed, directed_plan[n].result);

      // hold the sender off once the table is done so the queue runs dry
      hold_until_drained();

      phase = 0;
      for (n = 0; n < RAND_ITEMS; n++) begin
         // reshuffle the traffic mix every 40 requests and the idle pattern every 150
         if (n % 40 == 0)
            phase = int'($urandom_range(0, 2));
         if (n % 150 == 0)
            quiet_spell = ($urandom_range(0, 3) == 0);
         if (n % 400 == 399)
            hold_until_drained();
         send_request(make_random_request(phase), 1'b0, '0);
      end

      hold_until_drained();
      // let any stray result surface before the verdict
      repeat (SETTLE) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== delta_timer_queue.f =====
hdl/dtq_pkg.sv
hdl/dtq_front.sv
hdl/dtq_engine.sv
hdl/delta_timer_queue.sv
sim/tb_top.sv
